[rtl/rdpu_pkg.sv]
package rdpu_pkg;

    // Fraction bits of every fixed-point value
    localparam int FRAC_BITS = 16;

    // Pipeline geometry
    localparam int PIPE_DEPTH = 48;
    localparam int GAIN_STEPS = 29;
    localparam int RATE_STEPS = 41;

    // Datapath widths
    localparam int GN_W = 95;
    localparam int RX_W = 96;

    // Gain and rate limits
    localparam logic [28:0] GAIN_MAX = 29'h1000_0000;
    localparam logic [40:0] RATE_CAP = 41'h100_0000_0000;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSTRATE_DIFF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRODUCT_DIFF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_SATURATION = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REACTION_ENABLE = 3'd5;

    typedef struct packed {
        logic signed [31:0] substrate_center;
        logic signed [31:0] substrate_top;
        logic signed [31:0] substrate_bottom;
        logic signed [31:0] substrate_left;
        logic signed [31:0] substrate_right;
        logic signed [31:0] product_center;
        logic signed [31:0] product_top;
        logic signed [31:0] product_bottom;
        logic signed [31:0] product_left;
        logic signed [31:0] product_right;
        logic [31:0]        step_x;
        logic [31:0]        step_y;
    } in_t;

    // Side data that travels down the pipeline with each item
    typedef struct packed {
        logic signed [31:0] sc;
        logic signed [31:0] pc;
        logic signed [33:0] lsx;
        logic signed [33:0] lsy;
        logic signed [33:0] lpx;
        logic signed [33:0] lpy;
        logic [63:0]        dx2;
        logic [63:0]        dy2;
        logic [31:0]        sa;
        logic [32:0]        da;
        logic               neg;
        logic               dz;
        logic [63:0]        plo;
        logic [63:0]        phi;
        logic [RX_W-1:0]    xr;
        logic [28:0]        gsx;
        logic [28:0]        gsy;
        logic [28:0]        gpx;
        logic [28:0]        gpy;
        logic signed [63:0] mxs;
        logic signed [63:0] mys;
        logic signed [63:0] mxp;
        logic signed [63:0] myp;
        logic signed [65:0] ds;
        logic signed [65:0] dp;
        logic signed [41:0] rate;
        logic               flag;
    } side_t;

    // One stage of the gain divider
    typedef struct packed {
        logic [GN_W-1:0] n;
        logic [63:0]     d;
        logic [28:0]     q;
        logic            sat;
    } gdiv_t;

    // One stage of the rate divider
    typedef struct packed {
        logic [RX_W-1:0] x;
        logic [32:0]     d;
        logic [40:0]     q;
        logic            cap;
    } rdiv_t;

    // Load dividend num*2^F, flag a quotient that cannot fit the gain range
    function automatic gdiv_t gain_setup(logic [63:0] num, logic [63:0] den);
        gdiv_t g;
        g.n   = GN_W'(num) << FRAC_BITS;
        g.d   = den;
        g.q   = '0;
        g.sat = (num != '0) && (g.n >= (GN_W'(den) << GAIN_STEPS));
        return g;
    endfunction

    // Restoring step for quotient bit i
    function automatic gdiv_t gain_step(gdiv_t g, int i);
        gdiv_t       r;
        logic [GN_W-1:0] t;
        r = g;
        t = GN_W'(g.d) << i;
        if (g.n >= t) begin
            r.n    = g.n - t;
            r.q[i] = 1'b1;
        end
        return r;
    endfunction

    // Clamp a finished gain: {overflow, gain}
    function automatic logic [29:0] gain_clamp(gdiv_t g);
        logic big;
        big = g.sat || (g.q > GAIN_MAX);
        return {big, big ? GAIN_MAX : g.q};
    endfunction

    function automatic rdiv_t rate_setup(logic [RX_W-1:0] x, logic [32:0] d);
        rdiv_t r;
        r.x   = x;
        r.d   = d;
        r.q   = '0;
        r.cap = (x >= (RX_W'(d) << RATE_STEPS));
        return r;
    endfunction

    function automatic rdiv_t rate_step(rdiv_t g, int i);
        rdiv_t           r;
        logic [RX_W-1:0] t;
        r = g;
        t = RX_W'(g.d) << i;
        if (g.x >= t) begin
            r.x    = g.x - t;
            r.q[i] = 1'b1;
        end
        return r;
    endfunction

    // Clamp to the signed 32 bit range: {overflow, value}
    function automatic logic [32:0] sat32(logic signed [66:0] v);
        logic signed [66:0] hi;
        logic signed [66:0] lo;
        hi = 67'sd2147483647;
        lo = -67'sd2147483648;
        if (v > hi) begin
            return {1'b1, 32'h7fff_ffff};
        end
        if (v < lo) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

endpackage

[rtl/reaction_diffusion_point_update.sv]
// An accepted item passes in_reg, the side stages 2 to 47 and the output register to the m_ channel.
// Throughput: one item per cycle; a stalled result freezes the whole pipeline.
// Depth is set by the 41-stage restoring divider for the reaction rate,
// fed by a 64x32 product split over two 32x32 multipliers.
// Reset (aresetn low, synchronous) clears all valid bits and the config registers.
module reaction_diffusion_point_update (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [31:0]                s_substrate_center,
    input  logic signed [31:0]                s_substrate_top,
    input  logic signed [31:0]                s_substrate_bottom,
    input  logic signed [31:0]                s_substrate_left,
    input  logic signed [31:0]                s_substrate_right,
    input  logic signed [31:0]                s_product_center,
    input  logic signed [31:0]                s_product_top,
    input  logic signed [31:0]                s_product_bottom,
    input  logic signed [31:0]                s_product_left,
    input  logic signed [31:0]                s_product_right,
    input  logic [31:0]                       s_step_x,
    input  logic [31:0]                       s_step_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [31:0]                m_new_substrate,
    output logic signed [31:0]                m_new_product,
    output logic                              m_overflow_flag,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rdpu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_data
);

    localparam int GS = rdpu_pkg::GAIN_STEPS;
    localparam int RS = rdpu_pkg::RATE_STEPS;

    // Configuration registers and their products
    logic [31:0] time_step_reg;
    logic [31:0] substrate_diffusivity_reg;
    logic [31:0] product_diffusivity_reg;
    logic [31:0] max_rate_reg;
    logic [31:0] half_saturation_reg;
    logic        reaction_enable_reg;
    logic [63:0] ns_reg;
    logic [63:0] np_reg;
    logic [63:0] pr_reg;

    logic                 advance;
    logic [48:1]          v_reg;
    rdpu_pkg::in_t        in_reg;
    rdpu_pkg::in_t        in_next;
    rdpu_pkg::side_t      side_reg  [2:47];
    rdpu_pkg::side_t      side_next [2:47];
    rdpu_pkg::gdiv_t      gd_reg    [0:3][0:GS];
    rdpu_pkg::gdiv_t      gd_next   [0:3][0:GS];
    rdpu_pkg::rdiv_t      rd_reg    [0:RS];
    rdpu_pkg::rdiv_t      rd_next   [0:RS];
    logic [32:0]          sat_s;
    logic [32:0]          sat_p;
    logic signed [31:0]   out_s_reg;
    logic signed [31:0]   out_p_reg;
    logic                 out_f_reg;

    // Stage functions
    function automatic rdpu_pkg::side_t stage2(rdpu_pkg::in_t a, logic [31:0] km);
        rdpu_pkg::side_t     s;
        logic signed [33:0]  den;
        logic signed [33:0]  c34;
        s     = '0;
        c34   = 34'(a.substrate_center);
        s.sc  = a.substrate_center;
        s.pc  = a.product_center;
        s.lsx = 34'(a.substrate_left) + 34'(a.substrate_right) - (c34 <<< 1);
        s.lsy = 34'(a.substrate_top) + 34'(a.substrate_bottom) - (c34 <<< 1);
        s.lpx = 34'(a.product_left) + 34'(a.product_right)
              - (34'(a.product_center) <<< 1);
        s.lpy = 34'(a.product_top) + 34'(a.product_bottom)
              - (34'(a.product_center) <<< 1);
        s.dx2 = {32'b0, a.step_x} * {32'b0, a.step_x};
        s.dy2 = {32'b0, a.step_y} * {32'b0, a.step_y};
        s.sa  = a.substrate_center[31] ? 32'(-c34) : 32'(c34);
        den   = $signed({2'b00, km}) + c34;
        s.dz  = (den == '0);
        s.neg = a.substrate_center[31] ^ den[33];
        s.da  = den[33] ? 33'(-den) : 33'(den);
        return s;
    endfunction

    function automatic rdpu_pkg::side_t stage33(rdpu_pkg::side_t p, rdpu_pkg::gdiv_t g0,
        rdpu_pkg::gdiv_t g1, rdpu_pkg::gdiv_t g2, rdpu_pkg::gdiv_t g3);
        rdpu_pkg::side_t s;
        logic [29:0]     c0;
        logic [29:0]     c1;
        logic [29:0]     c2;
        logic [29:0]     c3;
        s      = p;
        c0     = rdpu_pkg::gain_clamp(g0);
        c1     = rdpu_pkg::gain_clamp(g1);
        c2     = rdpu_pkg::gain_clamp(g2);
        c3     = rdpu_pkg::gain_clamp(g3);
        s.gsx  = c0[28:0];
        s.gsy  = c1[28:0];
        s.gpx  = c2[28:0];
        s.gpy  = c3[28:0];
        s.flag = p.flag | c0[29] | c1[29] | c2[29] | c3[29];
        return s;
    endfunction

    function automatic rdpu_pkg::side_t stage34(rdpu_pkg::side_t p);
        rdpu_pkg::side_t s;
        s     = p;
        s.mxs = $signed({1'b0, p.gsx}) * p.lsx;
        s.mys = $signed({1'b0, p.gsy}) * p.lsy;
        s.mxp = $signed({1'b0, p.gpx}) * p.lpx;
        s.myp = $signed({1'b0, p.gpy}) * p.lpy;
        return s;
    endfunction

    function automatic rdpu_pkg::side_t stage35(rdpu_pkg::side_t p);
        rdpu_pkg::side_t    s;
        logic signed [65:0] acc_s;
        logic signed [65:0] acc_p;
        s     = p;
        acc_s = (66'(p.sc) <<< rdpu_pkg::FRAC_BITS) + 66'(p.mxs) + 66'(p.mys);
        acc_p = (66'(p.pc) <<< rdpu_pkg::FRAC_BITS) + 66'(p.mxp) + 66'(p.myp);
        s.ds  = acc_s >>> rdpu_pkg::FRAC_BITS;
        s.dp  = acc_p >>> rdpu_pkg::FRAC_BITS;
        return s;
    endfunction

    function automatic rdpu_pkg::side_t stage47(rdpu_pkg::side_t p, rdpu_pkg::rdiv_t r,
        logic en);
        rdpu_pkg::side_t    s;
        logic [40:0]        mag;
        logic signed [41:0] m42;
        s   = p;
        mag = (r.cap || (r.q > rdpu_pkg::RATE_CAP)) ? rdpu_pkg::RATE_CAP : r.q;
        m42 = $signed({1'b0, mag});
        if (!en || p.dz) begin
            s.rate = '0;
        end else begin
            s.rate = p.neg ? -m42 : m42;
        end
        s.flag = p.flag | (en & p.dz);
        return s;
    endfunction

    // Whole pipeline moves when the output register is free or being taken
    assign advance   = !v_reg[48] || m_ready;
    assign s_ready   = advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = v_reg[48];
    assign m_new_substrate = out_s_reg;
    assign m_new_product   = out_p_reg;
    assign m_overflow_flag = out_f_reg;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg             <= '0;
            substrate_diffusivity_reg <= '0;
            product_diffusivity_reg   <= '0;
            max_rate_reg              <= '0;
            half_saturation_reg       <= '0;
            reaction_enable_reg       <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rdpu_pkg::CFG_TIME_STEP:       time_step_reg <= cfg_data;
                rdpu_pkg::CFG_SUBSTRATE_DIFF:  substrate_diffusivity_reg <= cfg_data;
                rdpu_pkg::CFG_PRODUCT_DIFF:    product_diffusivity_reg <= cfg_data;
                rdpu_pkg::CFG_MAX_RATE:        max_rate_reg <= cfg_data;
                rdpu_pkg::CFG_HALF_SATURATION: half_saturation_reg <= cfg_data;
                rdpu_pkg::CFG_REACTION_ENABLE: reaction_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Form dt*D and dt*Vmax once per cycle from the config registers
    always_ff @(posedge aclk) begin
        ns_reg <= {32'b0, time_step_reg} * {32'b0, substrate_diffusivity_reg};
        np_reg <= {32'b0, time_step_reg} * {32'b0, product_diffusivity_reg};
        pr_reg <= {32'b0, time_step_reg} * {32'b0, max_rate_reg};
    end

    // Capture the input item
    always_comb begin
        in_next.substrate_center = s_substrate_center;
        in_next.substrate_top    = s_substrate_top;
        in_next.substrate_bottom = s_substrate_bottom;
        in_next.substrate_left   = s_substrate_left;
        in_next.substrate_right  = s_substrate_right;
        in_next.product_center   = s_product_center;
        in_next.product_top      = s_product_top;
        in_next.product_bottom   = s_product_bottom;
        in_next.product_left     = s_product_left;
        in_next.product_right    = s_product_right;
        in_next.step_x           = s_step_x;
        in_next.step_y           = s_step_y;
    end

    // Side data stages
    assign side_next[2] = stage2(in_reg, half_saturation_reg);

    for (genvar k = 3; k <= 47; k++) begin : g_side
        if (k == 3) begin : g_mul
            always_comb begin
                side_next[k]     = side_reg[k-1];
                side_next[k].plo = {32'b0, pr_reg[31:0]}  * {32'b0, side_reg[k-1].sa};
                side_next[k].phi = {32'b0, pr_reg[63:32]} * {32'b0, side_reg[k-1].sa};
            end
        end else if (k == 4) begin : g_sum
            always_comb begin
                side_next[k]    = side_reg[k-1];
                side_next[k].xr = ({32'b0, side_reg[k-1].plo} + {side_reg[k-1].phi, 32'b0})
                                  >> rdpu_pkg::FRAC_BITS;
            end
        end else if (k == 33) begin : g_gain
            assign side_next[k] = stage33(side_reg[k-1], gd_reg[0][GS], gd_reg[1][GS],
                                          gd_reg[2][GS], gd_reg[3][GS]);
        end else if (k == 34) begin : g_prod
            assign side_next[k] = stage34(side_reg[k-1]);
        end else if (k == 35) begin : g_acc
            assign side_next[k] = stage35(side_reg[k-1]);
        end else if (k == 47) begin : g_rate
            assign side_next[k] = stage47(side_reg[k-1], rd_reg[RS], reaction_enable_reg);
        end else begin : g_pass
            assign side_next[k] = side_reg[k-1];
        end
    end

    // Gain dividers: dt*D*2^F over step^2, one quotient bit per stage
    for (genvar u = 0; u < 4; u++) begin : g_gdiv
        assign gd_next[u][0] = rdpu_pkg::gain_setup((u < 2) ? ns_reg : np_reg,
                                   (u % 2 == 0) ? side_reg[2].dx2 : side_reg[2].dy2);
        for (genvar k = 1; k <= GS; k++) begin : g_step
            assign gd_next[u][k] = rdpu_pkg::gain_step(gd_reg[u][k-1], GS - k);
        end
    end

    // Rate divider: dt*Vmax*|S|/2^F over |Km+S|, one quotient bit per stage
    assign rd_next[0] = rdpu_pkg::rate_setup(side_reg[4].xr, side_reg[4].da);
    for (genvar k = 1; k <= RS; k++) begin : g_rstep
        assign rd_next[k] = rdpu_pkg::rate_step(rd_reg[k-1], RS - k);
    end

    // Final combine and saturate
    assign sat_s = rdpu_pkg::sat32(67'(side_reg[47].ds) - 67'(side_reg[47].rate));
    assign sat_p = rdpu_pkg::sat32(67'(side_reg[47].dp) + 67'(side_reg[47].rate));

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (advance) begin
            v_reg <= {v_reg[47:1], s_valid};
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            in_reg    <= in_next;
            side_reg  <= side_next;
            gd_reg    <= gd_next;
            rd_reg    <= rd_next;
            out_s_reg <= sat_s[31:0];
            out_p_reg <= sat_p[31:0];
            out_f_reg <= side_reg[47].flag | sat_s[32] | sat_p[32];
        end
    end

    // Gain divider 0 leaves a remainder below the divisor
    a_gain_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[32] && !gd_reg[0][GS].sat) |->
        ((gd_reg[0][GS].n < rdpu_pkg::GN_W'(gd_reg[0][GS].d)) || (gd_reg[0][GS].n == '0)))
        else $error("gain divider remainder not below divisor");

    // Rate division leaves a remainder below the divisor
    a_rate_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[46] && !rd_reg[RS].cap) |->
        ((rd_reg[RS].x < rdpu_pkg::RX_W'(rd_reg[RS].d)) || (rd_reg[RS].x == '0)))
        else $error("rate divider remainder not below divisor");

    // Clamped gains stay within range
    a_gain_max: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[33] |-> ((side_reg[33].gsx <= rdpu_pkg::GAIN_MAX)
                    && (side_reg[33].gsy <= rdpu_pkg::GAIN_MAX)
                    && (side_reg[33].gpx <= rdpu_pkg::GAIN_MAX)
                    && (side_reg[33].gpy <= rdpu_pkg::GAIN_MAX)))
        else $error("gain exceeds limit");

    // Reaction rate magnitude stays within the cap
    a_rate_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[47] |-> ((side_reg[47].rate <= $signed({1'b0, rdpu_pkg::RATE_CAP}))
                    && (side_reg[47].rate >= -$signed({1'b0, rdpu_pkg::RATE_CAP}))))
        else $error("reaction rate exceeds cap");

endmodule

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 160;

    // One predicted result
    typedef struct {
        logic signed [31:0] substrate;
        logic signed [31:0] product;
        logic               overflow;
    } point_result_t;

    // Predicts each grid point update and checks results in order
    class point_scoreboard;
        logic [31:0]        dt, d_sub, d_prod, vmax, km;
        logic               react_en;
        point_result_t      pending_q[$];
        int                 errors;
        int                 checked;
        int                 zero_den_hits;
        int                 ovf_hits;

        function new();
            dt = '0; d_sub = '0; d_prod = '0; vmax = '0; km = '0; react_en = 1'b0;
            errors = 0; checked = 0; zero_den_hits = 0; ovf_hits = 0;
        endfunction

        function void set_reg(logic [rdpu_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                rdpu_pkg::CFG_TIME_STEP:       dt = data;
                rdpu_pkg::CFG_SUBSTRATE_DIFF:  d_sub = data;
                rdpu_pkg::CFG_PRODUCT_DIFF:    d_prod = data;
                rdpu_pkg::CFG_MAX_RATE:        vmax = data;
                rdpu_pkg::CFG_HALF_SATURATION: km = data;
                rdpu_pkg::CFG_REACTION_ENABLE: react_en = data[0];
                default: ;
            endcase
        endfunction

        // floor(num * 2^F / den) clamped to the gain limit: {overflow, gain}
        function logic [29:0] quantized_gain(logic [63:0] num, logic [63:0] den);
            logic [95:0] g;
            if (num == '0) return '0;
            if (den == '0) return {1'b1, rdpu_pkg::GAIN_MAX};
            g = ({32'b0, num} << rdpu_pkg::FRAC_BITS) / {32'b0, den};
            if (g > {67'b0, rdpu_pkg::GAIN_MAX}) return {1'b1, rdpu_pkg::GAIN_MAX};
            return {1'b0, g[28:0]};
        endfunction

        // Five-point update, exact sum then floor shift
        function logic signed [79:0] diffused(logic signed [31:0] c, logic signed [31:0] t,
                                              logic signed [31:0] b, logic signed [31:0] l,
                                              logic signed [31:0] r, logic [28:0] gx,
                                              logic [28:0] gy);
            logic signed [79:0] acc;
            logic signed [79:0] lap_x;
            logic signed [79:0] lap_y;
            acc = c;
            acc = acc <<< rdpu_pkg::FRAC_BITS;
            lap_x = l;
            lap_x = lap_x + r - 2 * c;
            lap_y = t;
            lap_y = lap_y + b - 2 * c;
            acc = acc + $signed({51'b0, gx}) * lap_x + $signed({51'b0, gy}) * lap_y;
            return acc >>> rdpu_pkg::FRAC_BITS;
        endfunction

        function logic [32:0] clamp32(logic signed [79:0] v);
            if (v > 80'sd2147483647) return {1'b1, 32'h7fff_ffff};
            if (v < -80'sd2147483648) return {1'b1, 32'h8000_0000};
            return {1'b0, v[31:0]};
        endfunction

        function point_result_t predict(rdpu_pkg::in_t it);
            point_result_t      res;
            logic               flag;
            logic [63:0]        dx2, dy2, ns, np, p;
            logic [29:0]        gsx, gsy, gpx, gpy;
            logic signed [79:0] ds, dp, den, rate, sa, da;
            logic [127:0]       x, q;
            logic [32:0]        os, op;
            dx2 = 64'(it.step_x) * 64'(it.step_x);
            dy2 = 64'(it.step_y) * 64'(it.step_y);
            ns = 64'(dt) * 64'(d_sub);
            np = 64'(dt) * 64'(d_prod);
            gsx = quantized_gain(ns, dx2);
            gsy = quantized_gain(ns, dy2);
            gpx = quantized_gain(np, dx2);
            gpy = quantized_gain(np, dy2);
            flag = gsx[29] | gsy[29] | gpx[29] | gpy[29];
            ds = diffused(it.substrate_center, it.substrate_top, it.substrate_bottom,
                          it.substrate_left, it.substrate_right, gsx[28:0], gsy[28:0]);
            dp = diffused(it.product_center, it.product_top, it.product_bottom,
                          it.product_left, it.product_right, gpx[28:0], gpy[28:0]);
            rate = '0;
            if (react_en) begin
                den = $signed({48'b0, km});
                den = den + it.substrate_center;
                if (den == 0) begin
                    flag = 1'b1;
                    zero_den_hits++;
                end else begin
                    sa = it.substrate_center;
                    if (sa < 0) sa = -sa;
                    da = (den < 0) ? -den : den;
                    p = 64'(vmax) * 64'(dt);
                    x = ({64'b0, p} * {96'b0, sa[31:0]}) >> rdpu_pkg::FRAC_BITS;
                    q = x / {48'b0, da};
                    if (q > {87'b0, rdpu_pkg::RATE_CAP}) q = {87'b0, rdpu_pkg::RATE_CAP};
                    rate = $signed({1'b0, q[78:0]});
                    if ((it.substrate_center < 0) != (den < 0)) rate = -rate;
                end
            end
            os = clamp32(ds - rate);
            op = clamp32(dp + rate);
            res.substrate = os[31:0];
            res.product = op[31:0];
            res.overflow = flag | os[32] | op[32];
            return res;
        endfunction

        function void note_input(rdpu_pkg::in_t it);
            pending_q.push_back(predict(it));
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic signed [31:0] s, logic signed [31:0] p, logic f);
            point_result_t exp_r;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result s=%0d p=%0d f=%0b", s, p, f));
                return;
            end
            exp_r = pending_q.pop_front();
            checked++;
            if (exp_r.overflow) ovf_hits++;
            if (s !== exp_r.substrate)
                report($sformatf("item %0d new_substrate %0d, expected %0d",
                                 checked, s, exp_r.substrate));
            if (p !== exp_r.product)
                report($sformatf("item %0d new_product %0d, expected %0d",
                                 checked, p, exp_r.product));
            if (f !== exp_r.overflow)
                report($sformatf("item %0d overflow_flag %0b, expected %0b",
                                 checked, f, exp_r.overflow));
        endtask
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    rdpu_pkg::in_t      s_item;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_new_substrate;
    logic signed [31:0] m_new_product;
    logic               m_overflow_flag;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [rdpu_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]        cfg_data;

    point_scoreboard    sb;
    int                 tx_idle_pct;
    int                 rx_idle_pct;
    int                 quiet_cycles;
    int                 items_sent;

    reaction_diffusion_point_update dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_substrate_center (s_item.substrate_center),
        .s_substrate_top    (s_item.substrate_top),
        .s_substrate_bottom (s_item.substrate_bottom),
        .s_substrate_left   (s_item.substrate_left),
        .s_substrate_right  (s_item.substrate_right),
        .s_product_center   (s_item.product_center),
        .s_product_top      (s_item.product_top),
        .s_product_bottom   (s_item.product_bottom),
        .s_product_left     (s_item.product_left),
        .s_product_right    (s_item.product_right),
        .s_step_x           (s_item.step_x),
        .s_step_y           (s_item.step_y),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_new_substrate    (m_new_substrate),
        .m_new_product      (m_new_product),
        .m_overflow_flag    (m_overflow_flag),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Sample both channels and guard against a hung pipeline
    always @(posedge aclk) begin
        if (aresetn && sb != null) begin
            if (s_valid && s_ready) sb.note_input(s_item);
            if (m_valid && m_ready)
                sb.check_result(m_new_substrate, m_new_product, m_overflow_flag);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout after %0d idle cycles", quiet_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Receiver backpressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task send_point(rdpu_pkg::in_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        @(negedge aclk);
    endtask

    // Drop valid and let every outstanding result come back
    task drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending_q.size() != 0) @(negedge aclk);
        repeat (rdpu_pkg::PIPE_DEPTH + 4) @(negedge aclk);
    endtask

    task write_reg(logic [rdpu_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task load_settings(logic [31:0] dt, logic [31:0] ds, logic [31:0] dp,
                       logic [31:0] vm, logic [31:0] km, logic en);
        write_reg(rdpu_pkg::CFG_TIME_STEP, dt);
        write_reg(rdpu_pkg::CFG_SUBSTRATE_DIFF, ds);
        write_reg(rdpu_pkg::CFG_PRODUCT_DIFF, dp);
        write_reg(rdpu_pkg::CFG_MAX_RATE, vm);
        write_reg(rdpu_pkg::CFG_HALF_SATURATION, km);
        write_reg(rdpu_pkg::CFG_REACTION_ENABLE, {31'b0, en});
    endtask

    function logic [31:0] rand_conc();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) return $urandom_range(0, 1 << 21) - (1 << 20);
        if (pick < 85) return $urandom;
        case ($urandom_range(3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    function logic [31:0] rand_step();
        int          pick;
        logic [31:0] v;
        pick = $urandom_range(99);
        if (pick < 75) return $urandom_range(1 << 14, 1 << 18);
        if (pick < 90) begin
            v = $urandom;
            return (v == 0) ? 32'd1 : v;
        end
        return $urandom_range(1) ? 32'd1 : 32'hffff_ffff;
    endfunction

    function rdpu_pkg::in_t rand_point();
        rdpu_pkg::in_t it;
        it.substrate_center = rand_conc();
        it.substrate_top    = rand_conc();
        it.substrate_bottom = rand_conc();
        it.substrate_left   = rand_conc();
        it.substrate_right  = rand_conc();
        it.product_center   = rand_conc();
        it.product_top      = rand_conc();
        it.product_bottom   = rand_conc();
        it.product_left     = rand_conc();
        it.product_right    = rand_conc();
        it.step_x           = rand_step();
        it.step_y           = rand_step();
        // Hit the zero denominator now and then
        if ($urandom_range(99) < 5) it.substrate_center = -$signed(sb.km);
        return it;
    endfunction

    function rdpu_pkg::in_t flat_point(logic [31:0] s, logic [31:0] p, logic [31:0] sx,
                                       logic [31:0] sy);
        rdpu_pkg::in_t it;
        it.substrate_center = s; it.substrate_top = s; it.substrate_bottom = s;
        it.substrate_left = s; it.substrate_right = s;
        it.product_center = p; it.product_top = p; it.product_bottom = p;
        it.product_left = p; it.product_right = p;
        it.step_x = sx;
        it.step_y = sy;
        return it;
    endfunction

    task directed_points();
        rdpu_pkg::in_t it;
        for (int i = 0; i < 20; i++) begin
            it = rand_point();
            case (i)
                0: it = flat_point(32'h0, 32'h0, 32'h1_0000, 32'h1_0000);
                1: it = flat_point(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
                2: it = flat_point(32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1);
                3: it = flat_point(-sb.km, 32'h1234, 32'h1_0000, 32'h1_0000);
                4: begin
                    it = flat_point(32'h8000_0000, 32'h7fff_ffff, 32'h1_0000, 32'h1_0000);
                    it.substrate_center = 32'h7fff_ffff;
                    it.product_center = 32'h8000_0000;
                end
                5: begin
                    it.step_x = 32'd1;
                    it.step_y = 32'h1_0000;
                end
                6: begin
                    it.step_x = 32'hffff_ffff;
                    it.step_y = 32'd1;
                end
                7: it.substrate_center = -sb.km - 1;
                8: it.substrate_center = 32'hffff_0000;
                9: it.substrate_center = 32'h8000_0000;
                default: it.step_x = $urandom_range(1 << 15, 1 << 17);
            endcase
            send_point(it);
        end
    endtask

    task random_phase(int count, int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) send_point(rand_point());
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = rdpu_pkg::CFG_TIME_STEP;
        cfg_data = '0;
        tx_idle_pct = 17;
        rx_idle_pct = 87;
        quiet_cycles = 0;
        items_sent = 0;
        sb = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed points with the reaction on
        load_settings(32'h1000, 32'h1_0000, 32'h8000, 32'h2_0000, 32'h5_0000, 1'b1);
        directed_points();
        drain();

        // Busy sender, slow receiver
        load_settings($urandom_range(1, 2000), $urandom_range(0, 1 << 18),
                      $urandom_range(0, 1 << 18), $urandom_range(0, 1 << 20),
                      $urandom_range(0, 1 << 20), 1'b1);
        random_phase(ITEMS_PER_PHASE, 17, 87);
        load_settings('1, '1, '1, '1, '1, 1'b1);
        random_phase(ITEMS_PER_PHASE, 17, 87);

        // Slow sender, busy receiver
        load_settings('0, '0, '0, '0, '0, 1'b0);
        random_phase(ITEMS_PER_PHASE, 87, 17);
        load_settings($urandom, $urandom, $urandom, $urandom, $urandom,
                      1'($urandom_range(1)));
        random_phase(ITEMS_PER_PHASE, 87, 17);

        // Full rate both ways
        load_settings($urandom_range(1, 2000), $urandom_range(0, 1 << 18),
                      $urandom_range(0, 1 << 18), $urandom_range(0, 1 << 20),
                      $urandom_range(0, 1 << 20), 1'b0);
        random_phase(ITEMS_PER_PHASE, 0, 0);
        load_settings($urandom_range(1, 4000), $urandom_range(0, 1 << 20),
                      $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 24),
                      $urandom_range(0, 1 << 22), 1'b1);
        random_phase(ITEMS_PER_PHASE, 0, 0);

        repeat (rdpu_pkg::PIPE_DEPTH + 10) @(negedge aclk);
        $display("Sent %0d grid points over 7 register settings, %0d results checked",
                 items_sent, sb.checked);
        $display("Overflow flagged on %0d results, zero Km+S hit %0d times",
                 sb.ovf_hits, sb.zero_den_hits);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending_q.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
